>>> rtl/ita_pkg.sv
// Package with the shared types, character constants and digit mapping of the radix text converter.
`default_nettype none
package ita_pkg;

    localparam logic [7:0] MINUS_CHAR    = 8'd45;
    localparam logic [7:0] DIGIT_BASE    = 8'd48;
    localparam logic [7:0] LETTER_BASE   = 8'd55;
    localparam logic [5:0] DECIMAL_LIMIT = 6'd10;
    localparam logic [5:0] RADIX_MIN     = 6'd2;
    localparam logic [5:0] RADIX_MAX     = 6'd36;

    typedef struct packed {
        logic load;
        logic div_step;
        logic store;
        logic emit_sign;
        logic read;
        logic emit_digit;
    } t_ctrl_cmd;

    typedef struct packed {
        logic div_last;
        logic quot_zero;
        logic negative;
        logic count_zero;
        logic out_free;
    } t_dp_status;

    function automatic logic [7:0] digit_char(input logic [5:0] d);
        logic [7:0] d8;
        d8 = {2'b00, d};
        if (d < DECIMAL_LIMIT) begin
            digit_char = DIGIT_BASE + d8;
        end else begin
            digit_char = LETTER_BASE + d8;
        end
    endfunction

endpackage
`default_nettype wire

>>> rtl/ita_in_if.sv
// Input channel interface carrying one integer and its radix per transaction.
`default_nettype none
interface ita_in_if #(
    parameter int VALUE_WIDTH = 32
);
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] value;
    logic [5:0]             radix;

    modport source (output valid, output value, output radix, input ready);
    modport sink   (input valid, input value, input radix, output ready);
endinterface
`default_nettype wire

>>> rtl/ita_out_if.sv
// Output channel interface carrying one text character and its last mark per transaction.
`default_nettype none
interface ita_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic       last;

    modport source (output valid, output text_char, output last, input ready);
    modport sink   (input valid, input text_char, input last, output ready);
endinterface
`default_nettype wire

>>> rtl/ita_datapath.sv
// Datapath with the bit-serial divider, the digit memory and the output register.
`default_nettype none
module ita_datapath #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic [VALUE_WIDTH-1:0] i_value,
    input  wire logic [5:0]             i_radix,
    input  wire ita_pkg::t_ctrl_cmd     i_cmd,
    input  wire logic                   i_out_ready,
    output ita_pkg::t_dp_status         o_status,
    output logic                        o_out_valid,
    output logic [7:0]                  o_text_char,
    output logic                        o_last
);
    localparam int MAG_WIDTH = VALUE_WIDTH + 1;
    localparam int CNT_WIDTH = $clog2(VALUE_WIDTH + 1);
    localparam int IDX_WIDTH = $clog2(VALUE_WIDTH);
    localparam int BIT_WIDTH = $clog2(MAG_WIDTH);

    logic [5:0]           r_mem [VALUE_WIDTH];
    logic [MAG_WIDTH-1:0] r_mag;
    logic [5:0]           r_rem;
    logic [5:0]           r_radix;
    logic                 r_neg;
    logic [BIT_WIDTH-1:0] r_bit_cnt;
    logic [CNT_WIDTH-1:0] r_count;
    logic [5:0]           r_rd;
    logic                 r_out_valid;
    logic [7:0]           r_char;
    logic                 r_last;

    logic [6:0]             n_trial;
    logic                   n_qbit;
    logic [5:0]             n_rem;
    logic [5:0]             n_radix;
    logic [VALUE_WIDTH-1:0] n_abs;
    logic [CNT_WIDTH-1:0]   n_count_m1;

    always_comb begin
        n_trial = {r_rem, r_mag[MAG_WIDTH-1]};
        n_qbit  = (n_trial >= {1'b0, r_radix});
        n_rem   = n_qbit ? 6'(n_trial - {1'b0, r_radix}) : n_trial[5:0];
        if (i_radix < ita_pkg::RADIX_MIN) begin
            n_radix = ita_pkg::RADIX_MIN;
        end else if (i_radix > ita_pkg::RADIX_MAX) begin
            n_radix = ita_pkg::RADIX_MAX;
        end else begin
            n_radix = i_radix;
        end
        n_abs      = i_value[VALUE_WIDTH-1] ? (~i_value + 1'b1) : i_value;
        n_count_m1 = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store && (r_count < CNT_WIDTH'(VALUE_WIDTH))) begin
            r_mem[r_count[IDX_WIDTH-1:0]] <= r_rem;
        end
        if (i_cmd.read) begin
            r_rd <= r_mem[n_count_m1[IDX_WIDTH-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag       <= '0;
            r_rem       <= '0;
            r_radix     <= ita_pkg::RADIX_MIN;
            r_neg       <= 1'b0;
            r_bit_cnt   <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_mag     <= {1'b0, n_abs};
                r_rem     <= '0;
                r_radix   <= n_radix;
                r_neg     <= i_value[VALUE_WIDTH-1];
                r_bit_cnt <= '0;
                r_count   <= '0;
            end
            if (i_cmd.div_step) begin
                r_mag     <= {r_mag[MAG_WIDTH-2:0], n_qbit};
                r_rem     <= n_rem;
                r_bit_cnt <= r_bit_cnt + 1'b1;
            end
            if (i_cmd.store) begin
                r_rem     <= '0;
                r_bit_cnt <= '0;
                if (r_count < CNT_WIDTH'(VALUE_WIDTH)) begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (i_cmd.read) begin
                r_count <= n_count_m1;
            end
            if (i_cmd.emit_sign || i_cmd.emit_digit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_sign) begin
            r_char <= ita_pkg::MINUS_CHAR;
            r_last <= 1'b0;
        end else if (i_cmd.emit_digit) begin
            r_char <= ita_pkg::digit_char(r_rd);
            r_last <= (r_count == '0);
        end
    end

    assign o_status.div_last   = (r_bit_cnt == BIT_WIDTH'(MAG_WIDTH - 1));
    assign o_status.quot_zero  = (r_mag == '0);
    assign o_status.negative   = r_neg;
    assign o_status.count_zero = (r_count == '0);
    assign o_status.out_free   = !r_out_valid || i_out_ready;
    assign o_out_valid         = r_out_valid;
    assign o_text_char         = r_char;
    assign o_last              = r_last;
endmodule
`default_nettype wire

>>> rtl/ita_controller.sv
// Controller state machine that sequences division, digit storage and character output.
`default_nettype none
module ita_controller (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire ita_pkg::t_dp_status i_status,
    output logic                    o_in_ready,
    output ita_pkg::t_ctrl_cmd      o_cmd
);
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_STORE = 3'd2;
    localparam logic [2:0] ST_SIGN  = 3'd3;
    localparam logic [2:0] ST_READ  = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = ST_STORE;
                end
            end
            ST_STORE: begin
                o_cmd.store = 1'b1;
                if (!i_status.quot_zero) begin
                    n_state = ST_DIV;
                end else if (i_status.negative) begin
                    n_state = ST_SIGN;
                end else begin
                    n_state = ST_READ;
                end
            end
            ST_SIGN: begin
                if (i_status.out_free) begin
                    o_cmd.emit_sign = 1'b1;
                    n_state         = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.read = 1'b1;
                n_state    = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit_digit = 1'b1;
                    n_state          = i_status.count_zero ? ST_IDLE : ST_READ;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule
`default_nettype wire

>>> rtl/integer_to_radix_ascii.sv
// Top level of the integer to radix ASCII text converter.
// The input channel carries one signed integer and a radix per transaction; a radix
// below 2 is taken as 2 and one above 36 as 36. The output channel carries the text
// one character per transaction, most significant digit first, with a leading minus
// sign for negative values and last set on the final digit.
// Each digit comes from a bit-serial restoring divider that steps through all
// VALUE_WIDTH + 1 bits of the magnitude, followed by a store of the digit. Each
// character then needs a registered read of the digit memory and a load of the
// output register.
// The block works on one number at a time and accepts the next one as soon as the
// last character sits in the output register. When the receiver stalls, the output
// register holds its character and the sequencer waits.
// Reset clears the sequencer, the counters and the output valid flag; the digit
// memory needs no reset because each number writes its digits before reading them.
`default_nettype none
module integer_to_radix_ascii #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ita_in_if.sink     i_in,
    ita_out_if.source  o_out
);
    ita_pkg::t_ctrl_cmd  cmd;
    ita_pkg::t_dp_status status;

    ita_controller u_controller (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_status   (status),
        .o_in_ready (i_in.ready),
        .o_cmd      (cmd)
    );

    ita_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value     (i_in.value),
        .i_radix     (i_in.radix),
        .i_cmd       (cmd),
        .i_out_ready (o_out.ready),
        .o_status    (status),
        .o_out_valid (o_out.valid),
        .o_text_char (o_out.text_char),
        .o_last      (o_out.last)
    );

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load, cmd.div_step, cmd.store, cmd.emit_sign, cmd.read,
                  cmd.emit_digit}))
        else $error("More than one datapath command issued in one cycle.");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit_sign || cmd.emit_digit) |-> status.out_free)
        else $error("Character loaded while the output register was stalled.");

    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |=> !i_in.ready)
        else $error("Input still ready after a transaction was accepted.");

    a_load_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |-> cmd.load)
        else $error("Accepted transaction was not loaded into the datapath.");
endmodule
`default_nettype wire
